// ===== hdl/aie_pkg.sv =====
// Package for the ARM modified-immediate encoder: beat types and opcode codes.
package aie_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned FIELD_W  = 12;
    localparam int unsigned IMM_W    = 8;
    localparam int unsigned ROT_W    = 4;
    localparam int unsigned NUM_ROT  = 16;

    localparam logic [VALUE_W-1:0] HIGH_MASK = 32'hFFFF_FF00;

    localparam logic [OPCODE_W-1:0] OP_AND = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_SUB = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_ADD = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_ADC = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_SBC = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_CMP = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_CMN = 4'd11;
    localparam logic [OPCODE_W-1:0] OP_MOV = 4'd13;
    localparam logic [OPCODE_W-1:0] OP_BIC = 4'd14;
    localparam logic [OPCODE_W-1:0] OP_MVN = 4'd15;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OPCODE_W-1:0] opcode_in;
        logic                value_undefined;
    } aie_item_t;

    typedef struct packed {
        logic                fits;
        logic [FIELD_W-1:0]  imm_field;
        logic [OPCODE_W-1:0] opcode_out;
    } aie_result_t;

endpackage

// ===== hdl/arm_immediate_encoder_top.sv =====
// ARM modified-immediate encoder: input register, parallel rotation check, result register.
// A beat goes from the input register to the result register, which drives the result port.
// Throughput: one beat per cycle without result_ready stalls; input refills while result drains.
// All sixteen rotations are checked in parallel in the single stage between the two registers.
// Reset: rst_n asynchronous, active low; clears both valid flags, payload registers are not reset.
module arm_immediate_encoder_top
    import aie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  aie_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output aie_result_t result
);

    aie_item_t   item_reg;
    logic        stage_valid_reg;
    aie_result_t result_reg;
    logic        result_valid_reg;

    logic        out_free;
    logic        stage_move;
    aie_result_t result_next;

    logic [VALUE_W-1:0]  rot_val [NUM_ROT];
    logic [VALUE_W-1:0]  neg_val;
    logic [OPCODE_W-1:0] inv_op;
    logic                inv_ok;
    logic [OPCODE_W-1:0] neg_op;
    logic                neg_ok;

    assign out_free     = !result_valid_reg || result_ready;
    assign stage_move   = stage_valid_reg && out_free;
    assign item_ready   = !stage_valid_reg || out_free;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign rot_val[0] = item_reg.value;
    for (genvar r = 1; r < NUM_ROT; r++)
    begin : g_rot
        assign rot_val[r] = (item_reg.value << (2 * r)) | (item_reg.value >> (VALUE_W - 2 * r));
    end

    assign neg_val = '0 - item_reg.value;

    always_comb
    begin
        inv_ok = 1'b1;
        inv_op = item_reg.opcode_in;
        unique case (item_reg.opcode_in)
            OP_AND:  inv_op = OP_BIC;
            OP_MOV:  inv_op = OP_MVN;
            OP_ADC:  inv_op = OP_SBC;
            default: inv_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        neg_ok = 1'b1;
        neg_op = item_reg.opcode_in;
        unique case (item_reg.opcode_in)
            OP_ADD:  neg_op = OP_SUB;
            OP_CMP:  neg_op = OP_CMN;
            default: neg_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        result_next.fits       = 1'b0;
        result_next.imm_field  = '0;
        result_next.opcode_out = item_reg.opcode_in;
        if (!item_reg.value_undefined)
        begin
            if ((item_reg.value & HIGH_MASK) == '0)
            begin
                result_next.fits      = 1'b1;
                result_next.imm_field = {ROT_W'(0), item_reg.value[IMM_W-1:0]};
            end
            else if (((~item_reg.value) & HIGH_MASK) == '0 && inv_ok)
            begin
                result_next.fits       = 1'b1;
                result_next.imm_field  = {ROT_W'(0), ~item_reg.value[IMM_W-1:0]};
                result_next.opcode_out = inv_op;
            end
            else if ((neg_val & HIGH_MASK) == '0 && neg_ok)
            begin
                result_next.fits       = 1'b1;
                result_next.imm_field  = {ROT_W'(0), neg_val[IMM_W-1:0]};
                result_next.opcode_out = neg_op;
            end
            else
            begin
                for (int r = 1; r < NUM_ROT; r++)
                begin
                    if (!result_next.fits)
                    begin
                        if ((rot_val[r] & HIGH_MASK) == '0)
                        begin
                            result_next.fits      = 1'b1;
                            result_next.imm_field = {ROT_W'(r), rot_val[r][IMM_W-1:0]};
                        end
                        else if (((~rot_val[r]) & HIGH_MASK) == '0 && inv_ok)
                        begin
                            result_next.fits       = 1'b1;
                            result_next.imm_field  = {ROT_W'(r), ~rot_val[r][IMM_W-1:0]};
                            result_next.opcode_out = inv_op;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (out_free)
            begin
                result_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (stage_move)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fits |-> result.imm_field == '0)
        else $error("failed encoding carries a nonzero field");

    a_swap_needs_fit: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && result_next.opcode_out != item_reg.opcode_in |-> result_next.fits)
        else $error("opcode substituted without an encoding");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !out_free |=> stage_valid_reg && $stable(item_reg))
        else $error("input register changed while the result register was blocked");

    a_undef_fails: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && item_reg.value_undefined |-> !result_next.fits)
        else $error("undefined value produced an encoding");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the ARM immediate encoder: directed and random constants checked against a predictor.
module tb_top;
    import aie_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_EOR = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_ORR = 4'd12;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 366;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 4;

    class encoding_scoreboard;
        aie_result_t expected_encodings[$];
        int unsigned encoding_errors;

        function new();
            encoding_errors = 0;
        endfunction

        function aie_result_t encode_constant(aie_item_t it);
            aie_result_t        enc;
            logic [VALUE_W-1:0] rot;
            logic [VALUE_W-1:0] negated;
            logic [OPCODE_W-1:0] inv_op;
            logic [OPCODE_W-1:0] neg_op;
            logic               has_inv;
            logic               has_neg;
            enc.fits       = 1'b0;
            enc.imm_field  = '0;
            enc.opcode_out = it.opcode_in;
            has_inv = 1'b1;
            has_neg = 1'b1;
            inv_op  = it.opcode_in;
            neg_op  = it.opcode_in;
            case (it.opcode_in)
                OP_AND:  inv_op = OP_BIC;
                OP_MOV:  inv_op = OP_MVN;
                OP_ADC:  inv_op = OP_SBC;
                default: has_inv = 1'b0;
            endcase
            case (it.opcode_in)
                OP_ADD:  neg_op = OP_SUB;
                OP_CMP:  neg_op = OP_CMN;
                default: has_neg = 1'b0;
            endcase
            negated = 32'd0 - it.value;
            if (!it.value_undefined)
            begin
                if ((it.value & HIGH_MASK) == '0)
                begin
                    enc.fits      = 1'b1;
                    enc.imm_field = {4'd0, it.value[7:0]};
                end
                else if ((~it.value & HIGH_MASK) == '0 && has_inv)
                begin
                    enc.fits       = 1'b1;
                    enc.imm_field  = {4'd0, ~it.value[7:0]};
                    enc.opcode_out = inv_op;
                end
                else if ((negated & HIGH_MASK) == '0 && has_neg)
                begin
                    enc.fits       = 1'b1;
                    enc.imm_field  = {4'd0, negated[7:0]};
                    enc.opcode_out = neg_op;
                end
                else
                begin
                    rot = it.value;
                    for (int r = 1; r < NUM_ROT && !enc.fits; r++)
                    begin
                        rot = {rot[29:0], rot[31:30]};
                        if ((rot & HIGH_MASK) == '0)
                        begin
                            enc.fits      = 1'b1;
                            enc.imm_field = {r[3:0], rot[7:0]};
                        end
                        else if ((~rot & HIGH_MASK) == '0 && has_inv)
                        begin
                            enc.fits       = 1'b1;
                            enc.imm_field  = {r[3:0], ~rot[7:0]};
                            enc.opcode_out = inv_op;
                        end
                    end
                end
            end
            return enc;
        endfunction

        function void note_item(aie_item_t it);
            expected_encodings.push_back(encode_constant(it));
        endfunction

        function void check_result(aie_result_t got);
            aie_result_t want;
            if (expected_encodings.size() == 0)
            begin
                encoding_errors++;
                if (encoding_errors <= 10)
                    $display("unexpected result beat: fits=%0b field=%03h op=%0d",
                             got.fits, got.imm_field, got.opcode_out);
                return;
            end
            want = expected_encodings.pop_front();
            if (got.fits != want.fits || got.imm_field != want.imm_field ||
                got.opcode_out != want.opcode_out)
            begin
                encoding_errors++;
                if (encoding_errors <= 10)
                    $display("encoding mismatch: expected fits=%0b field=%03h op=%0d,",
                             want.fits, want.imm_field, want.opcode_out,
                             " got fits=%0b field=%03h op=%0d",
                             got.fits, got.imm_field, got.opcode_out);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    aie_item_t   item;
    logic        result_valid;
    logic        result_ready;
    aie_result_t result;

    encoding_scoreboard sb;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned hold_requests;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned cycle_count;

    arm_immediate_encoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic aie_item_t make_item(logic [VALUE_W-1:0] value,
                                            logic [OPCODE_W-1:0] op, logic undef);
        aie_item_t it;
        it.value           = value;
        it.opcode_in       = op;
        it.value_undefined = undef;
        return it;
    endfunction

    task automatic send_item(input aie_item_t it);
        int unsigned gaps;
        gaps = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            item_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
    endtask

    // drain side: check accepted beats, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(result);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [OPCODE_W-1:0] hot_ops[5];
        int unsigned         sender_phase[5];
        int unsigned         receiver_phase[5];
        logic [VALUE_W-1:0]  wide;
        logic [VALUE_W-1:0]  rotated;
        logic [VALUE_W-1:0]  value;
        logic [OPCODE_W-1:0] op;
        int unsigned         r;
        int unsigned         kind;

        hot_ops        = '{OP_AND, OP_ADD, OP_ADC, OP_CMP, OP_MOV};
        sender_phase   = '{0, 79, 0, 6, 0};
        receiver_phase = '{0, 0, 79, 6, 0};
        sb = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests = 0;
        hold_seen     = 0;
        hold_left     = 0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        result_ready <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(make_item(32'h0000_0000, OP_MOV, 1'b0));
        send_item(make_item(32'h0000_00FF, OP_ADD, 1'b0));
        send_item(make_item(32'h0000_0100, OP_MOV, 1'b0));
        send_item(make_item(32'hFFFF_FFFF, OP_AND, 1'b0));
        send_item(make_item(32'hFFFF_FFFF, OP_MOV, 1'b0));
        send_item(make_item(32'hFFFF_FF00, OP_ADC, 1'b0));
        send_item(make_item(32'hFFFF_FFFF, OP_EOR, 1'b0));
        send_item(make_item(32'hFFFF_FF01, OP_ADD, 1'b0));
        send_item(make_item(32'hFFFF_FFFF, OP_CMP, 1'b0));
        send_item(make_item(32'hFFFF_FF00, OP_CMP, 1'b0));
        send_item(make_item(32'hFFFF_F000, OP_ADD, 1'b0));
        send_item(make_item(32'hFF00_0000, OP_ORR, 1'b0));
        send_item(make_item(32'h0000_03FC, OP_ADD, 1'b0));
        send_item(make_item(32'hF000_000F, OP_CMP, 1'b0));
        send_item(make_item(32'h00FF_FFFF, OP_MOV, 1'b0));
        send_item(make_item(32'h00FF_FFFF, OP_ADD, 1'b0));
        send_item(make_item(32'hFFFF_FC03, OP_AND, 1'b0));
        send_item(make_item(32'h0000_0102, OP_MOV, 1'b0));
        send_item(make_item(32'h8000_0001, OP_ADC, 1'b0));
        send_item(make_item(32'h0000_0000, OP_MOV, 1'b1));
        send_item(make_item(32'hFFFF_FFFF, OP_AND, 1'b1));
        send_item(make_item(32'hFFFF_FFFF, OP_MVN, 1'b0));

        for (int ph = 0; ph < 5; ph++)
        begin
            sender_idle_pct    = sender_phase[ph];
            receiver_stall_pct = receiver_phase[ph];
            if (ph == 4)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 4 && n == ITEMS_PER_PHASE / 2)
                    hold_requests++;
                r       = $urandom_range(15);
                wide    = {24'd0, 8'($urandom_range(255))};
                rotated = (wide >> (2 * r)) | (wide << (32 - 2 * r));
                kind    = $urandom_range(9);
                case (kind)
                    0, 1, 2, 3: value = rotated;
                    4:          value = ~rotated;
                    5:          value = 32'd0 - rotated;
                    6:          value = rotated ^ (32'd1 << $urandom_range(31));
                    7:          value = {24'd0, 8'($urandom_range(255))} ^ {32{1'($urandom_range(1))}};
                    default:    value = $urandom;
                endcase
                if ($urandom_range(9) < 6)
                    op = hot_ops[$urandom_range(4)];
                else
                    op = 4'($urandom_range(15));
                send_item(make_item(value, op, $urandom_range(19) == 0));
            end
        end
        item_valid <= 1'b0;

        while (sb.expected_encodings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.encoding_errors == 0 && sb.expected_encodings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
